### sv/assert_macros.svh
// Assertion macros used by the checker file of the header parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define NHP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define NHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/nhp_pkg.sv
// Shared types, codes and helper functions of the network header parser.
// No dependencies.
package nhp_pkg;

  localparam int unsigned MAX_FRAME_LEN  = 127;
  localparam int unsigned MIN_HEADER_LEN = 8;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned HIDX_W         = $clog2(MIN_HEADER_LEN);

  // Result kinds
  localparam logic [3:0] KIND_FRAME_CTRL = 4'd0;
  localparam logic [3:0] KIND_DST_SHORT  = 4'd1;
  localparam logic [3:0] KIND_SRC_SHORT  = 4'd2;
  localparam logic [3:0] KIND_RADIUS     = 4'd3;
  localparam logic [3:0] KIND_SEQ        = 4'd4;
  localparam logic [3:0] KIND_DST_EXT    = 4'd5;
  localparam logic [3:0] KIND_SRC_EXT    = 4'd6;
  localparam logic [3:0] KIND_MCAST      = 4'd7;
  localparam logic [3:0] KIND_RCOUNT     = 4'd8;
  localparam logic [3:0] KIND_RINDEX     = 4'd9;
  localparam logic [3:0] KIND_RENTRY     = 4'd10;
  localparam logic [3:0] KIND_PAYLOAD    = 4'd11;
  localparam logic [3:0] KIND_RAW        = 4'd12;
  localparam logic [3:0] KIND_TRUNC      = 4'd13;

  // Item index of the last header result, and of a trailing error after it
  localparam logic [2:0] IDX_HDR_LAST = 3'd4;
  localparam logic [2:0] IDX_HDR_ERR  = 3'd5;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_DST_EXT = 8'b0000_0010,
    PH_SRC_EXT = 8'b0000_0100,
    PH_MCAST   = 8'b0000_1000,
    PH_RCOUNT  = 8'b0001_0000,
    PH_RINDEX  = 8'b0010_0000,
    PH_RENTRY  = 8'b0100_0000,
    PH_PAYLOAD = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_RAW    = 2'd2
  } entry_mode_e;

  // Option flag bit positions
  localparam int unsigned OPT_DST = 0;
  localparam int unsigned OPT_SRC = 1;
  localparam int unsigned OPT_MC  = 2;
  localparam int unsigned OPT_RL  = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } nhp_in_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [63:0] field_value;
    logic        last_of_frame;
  } nhp_out_t;

  // One queue entry: expands into one or more results in the back end
  typedef struct packed {
    entry_mode_e mode;
    logic [3:0]  kind;
    logic [63:0] value;
    logic [2:0]  last_idx;
    logic        frame_end;
    logic        err_tail;
  } nhp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nhp_qstat_t;

  function automatic logic [3:0] field_len(phase_e ph);
    logic [3:0] len;
    case (ph)
      PH_DST_EXT, PH_SRC_EXT: len = 4'd8;
      PH_RENTRY:              len = 4'd2;
      PH_HEADER, PH_PAYLOAD:  len = 4'd0;
      default:                len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] phase_kind(phase_e ph);
    logic [3:0] k;
    case (ph)
      PH_DST_EXT: k = KIND_DST_EXT;
      PH_SRC_EXT: k = KIND_SRC_EXT;
      PH_MCAST:   k = KIND_MCAST;
      PH_RCOUNT:  k = KIND_RCOUNT;
      PH_RINDEX:  k = KIND_RINDEX;
      default:    k = KIND_RENTRY;
    endcase
    return k;
  endfunction

  // Next phase after ph, following the announced options
  function automatic phase_e next_phase(phase_e ph, logic [3:0] flags, logic more_relays);
    logic   dst_ok, src_ok, mc_ok, rl_ok;
    phase_e nx;
    dst_ok = (ph == PH_HEADER);
    src_ok = dst_ok || (ph == PH_DST_EXT);
    mc_ok  = src_ok || (ph == PH_SRC_EXT);
    rl_ok  = mc_ok || (ph == PH_MCAST);
    if (dst_ok && flags[OPT_DST]) begin
      nx = PH_DST_EXT;
    end else if (src_ok && flags[OPT_SRC]) begin
      nx = PH_SRC_EXT;
    end else if (mc_ok && flags[OPT_MC]) begin
      nx = PH_MCAST;
    end else if (rl_ok && flags[OPT_RL]) begin
      nx = PH_RCOUNT;
    end else if (ph == PH_RCOUNT) begin
      nx = PH_RINDEX;
    end else if (((ph == PH_RINDEX) || (ph == PH_RENTRY)) && more_relays) begin
      nx = PH_RENTRY;
    end else begin
      nx = PH_PAYLOAD;
    end
    return nx;
  endfunction

endpackage

### sv/nhp_queue.sv
// Small register queue of parse entries between the front and back ends.
// Depends on nhp_pkg.
module nhp_queue import nhp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nhp_entry_t push_data_i,
  input  logic       pop_i,
  output nhp_entry_t head_o,
  output nhp_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nhp_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/nhp_front.sv
// Front end: accepts frame bytes, tracks the parse phase and assembles fields.
// Pushes one entry per completed field, payload byte or frame event. Depends on nhp_pkg.
module nhp_front import nhp_pkg::*; #(
  parameter int unsigned MaxFrameLen = MAX_FRAME_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nhp_in_t    in_data_i,
  input  nhp_qstat_t qstat_i,
  output logic       push_o,
  output nhp_entry_t push_data_o
);

  localparam int unsigned PosW = $clog2(MaxFrameLen + 1);

  logic [PosW-1:0]                   pos_q, pos_d;
  logic [MIN_HEADER_LEN-1:0][7:0]    head_q, head_d, head_merged;
  logic [7:0][7:0]                   shift_q, shift_d, shift_new;
  phase_e                            phase_q, phase_d, nx;
  logic [3:0]                        flags_q, flags_d, flags_new;
  logic [7:0]                        relays_q, relays_d, relays_new;
  logic [3:0]                        left_q, left_d, left_new, len;
  logic [2:0]                        k;
  logic                              accept, endf, restart, err;
  logic [7:0]                        b;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;
  assign endf       = in_data_i.frame_end ||
                      (({1'b0, pos_q} + (PosW + 1)'(1)) >= (PosW + 1)'(MaxFrameLen));

  always_comb begin
    head_merged = head_q;
    head_merged[pos_q[HIDX_W-1:0]] = b;
    len       = field_len(phase_q);
    k         = 3'(len - left_q);
    left_new  = left_q - 4'd1;
    shift_new = shift_q;
    shift_new[k] = b;
    flags_new = '0;
    flags_new[OPT_DST] = head_q[1][3];
    flags_new[OPT_SRC] = head_q[1][4];
    flags_new[OPT_MC]  = head_q[1][0];
    flags_new[OPT_RL]  = head_q[1][2];
    relays_new = relays_q;
    if (phase_q == PH_RCOUNT) begin
      relays_new = b;
    end else if ((phase_q == PH_RENTRY) && (relays_q != '0)) begin
      relays_new = relays_q - 8'd1;
    end
    if (phase_q == PH_HEADER) begin
      nx = next_phase(PH_HEADER, flags_new, 1'b0);
    end else begin
      nx = next_phase(phase_q, flags_q, relays_new != '0);
    end
    err = endf && (nx != PH_PAYLOAD);
  end

  always_comb begin
    pos_d       = pos_q;
    head_d      = head_q;
    shift_d     = shift_q;
    phase_d     = phase_q;
    flags_d     = flags_q;
    relays_d    = relays_q;
    left_d      = left_q;
    restart     = 1'b0;
    push_o      = 1'b0;
    push_data_o = '0;
    push_data_o.mode = MODE_SINGLE;

    if (accept) begin
      if ((phase_q != PH_HEADER) && (pos_q < PosW'(MaxFrameLen))) begin
        pos_d = pos_q + PosW'(1);
      end
      unique case (phase_q)
        PH_HEADER: begin
          head_d = head_merged;
          if (pos_q < PosW'(MIN_HEADER_LEN - 1)) begin
            if (endf) begin
              // short frame: replay the buffered bytes
              push_o                = 1'b1;
              push_data_o.mode      = MODE_RAW;
              push_data_o.kind      = KIND_RAW;
              push_data_o.value     = head_merged;
              push_data_o.last_idx  = pos_q[2:0];
              push_data_o.frame_end = 1'b1;
              restart               = 1'b1;
            end else begin
              pos_d = pos_q + PosW'(1);
            end
          end else begin
            push_o                = 1'b1;
            push_data_o.mode      = MODE_HEADER;
            push_data_o.kind      = KIND_FRAME_CTRL;
            push_data_o.value     = head_merged;
            push_data_o.last_idx  = err ? IDX_HDR_ERR : IDX_HDR_LAST;
            push_data_o.frame_end = endf;
            push_data_o.err_tail  = err;
            if (endf) begin
              restart = 1'b1;
            end else begin
              pos_d   = PosW'(MIN_HEADER_LEN);
              flags_d = flags_new;
              phase_d = nx;
              shift_d = '0;
              left_d  = field_len(nx);
            end
          end
        end
        PH_PAYLOAD: begin
          push_o                = 1'b1;
          push_data_o.kind      = KIND_PAYLOAD;
          push_data_o.value     = {56'd0, b};
          push_data_o.frame_end = endf;
          restart               = endf;
        end
        PH_DST_EXT, PH_SRC_EXT, PH_MCAST, PH_RCOUNT, PH_RINDEX, PH_RENTRY: begin
          if (left_new != '0) begin
            shift_d = shift_new;
            left_d  = left_new;
            if (endf) begin
              // frame ends inside a field
              push_o                = 1'b1;
              push_data_o.kind      = KIND_TRUNC;
              push_data_o.frame_end = 1'b1;
              restart               = 1'b1;
            end
          end else begin
            push_o                = 1'b1;
            push_data_o.kind      = phase_kind(phase_q);
            push_data_o.value     = shift_new;
            push_data_o.last_idx  = {2'b00, err};
            push_data_o.frame_end = endf;
            push_data_o.err_tail  = err;
            if (endf) begin
              restart = 1'b1;
            end else begin
              relays_d = relays_new;
              phase_d  = nx;
              shift_d  = '0;
              left_d   = field_len(nx);
            end
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end

    if (restart) begin
      pos_d    = '0;
      shift_d  = '0;
      phase_d  = PH_HEADER;
      flags_d  = '0;
      relays_d = '0;
      left_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      phase_q  <= PH_HEADER;
      flags_q  <= '0;
      relays_q <= '0;
      left_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      relays_q <= relays_d;
      left_q   <= left_d;
    end
  end

  // header bytes hold until overwritten by the next frame
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

endmodule

### sv/nhp_back.sv
// Back end: expands queue entries into result items through an output register.
// Depends on nhp_pkg.
module nhp_back import nhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  nhp_entry_t head_i,
  input  nhp_qstat_t qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output nhp_out_t   out_data_o
);

  logic       out_valid_q, out_valid_d;
  nhp_out_t   out_q, item;
  logic [2:0] idx_q, idx_d;
  logic       load, is_final;

  assign load     = !qstat_i.empty && (!out_valid_q || out_ready_i);
  assign is_final = (idx_q == head_i.last_idx);
  assign pop_o    = load && is_final;

  always_comb begin
    item.field_kind    = head_i.kind;
    item.field_value   = head_i.value;
    item.last_of_frame = is_final && head_i.frame_end;
    if (head_i.err_tail && is_final) begin
      item.field_kind  = KIND_TRUNC;
      item.field_value = '0;
    end else begin
      case (head_i.mode)
        MODE_HEADER: begin
          case (idx_q)
            3'd0: begin
              item.field_kind  = KIND_FRAME_CTRL;
              item.field_value = {48'd0, head_i.value[15:0]};
            end
            3'd1: begin
              item.field_kind  = KIND_DST_SHORT;
              item.field_value = {48'd0, head_i.value[31:16]};
            end
            3'd2: begin
              item.field_kind  = KIND_SRC_SHORT;
              item.field_value = {48'd0, head_i.value[47:32]};
            end
            3'd3: begin
              item.field_kind  = KIND_RADIUS;
              item.field_value = {56'd0, head_i.value[55:48]};
            end
            default: begin
              item.field_kind  = KIND_SEQ;
              item.field_value = {56'd0, head_i.value[63:56]};
            end
          endcase
        end
        MODE_RAW: begin
          item.field_kind  = KIND_RAW;
          item.field_value = {56'd0, head_i.value[idx_q*8 +: 8]};
        end
        default: begin
          item.field_kind  = head_i.kind;
          item.field_value = head_i.value;
        end
      endcase
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_final ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/nwk_header_parser.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i  (nhp_in_t: data_byte, frame_end)
// out     | output    | out_valid_o/out_ready_i | out_data_o (nhp_out_t: kind, value, last)
//
// Accepts one byte per cycle while the entry queue has room; each byte yields at
// most one queue entry. The output register drains one result per cycle unless
// stalled, so the 8th header byte (5-6 results) or a short frame (up to 7) stays
// in the back end while the queue (QueueDepth entries) absorbs the following bytes.
// Reset clears parse state and the queue at once; no clearing pass is needed.
// Either side may stall independently; a stalled result holds in the output register.
// Top level of the network header parser. Depends on nhp_pkg, nhp_front,
// nhp_queue and nhp_back.
module nwk_header_parser import nhp_pkg::*; #(
  parameter int unsigned MaxFrameLen = MAX_FRAME_LEN,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  nhp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output nhp_out_t out_data_o
);

  logic       push, pop;
  nhp_entry_t push_data, head;
  nhp_qstat_t qstat;

  nhp_front #(
    .MaxFrameLen(MaxFrameLen)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  nhp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  nhp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### sv/nhp_checker.sv
// Port-level checks of the network header parser, bound to the top level.
// Depends on nhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nhp_checker import nhp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input nhp_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input nhp_out_t out_data_o
);

  // hold a stalled result
  `NHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  `NHP_ASSERT(a_kind_range, clk_i, rst_ni, !out_valid_o || (out_data_o.field_kind <= KIND_TRUNC), "result kind out of range")

  `NHP_ASSERT(a_trunc_form, clk_i, rst_ni, !(out_valid_o && (out_data_o.field_kind == KIND_TRUNC)) || (out_data_o.last_of_frame && (out_data_o.field_value == '0)), "truncation result malformed")

  // frame control through radius are always followed by more header results
  `NHP_ASSERT(a_head_not_last, clk_i, rst_ni, !(out_valid_o && (out_data_o.field_kind < KIND_SEQ)) || !out_data_o.last_of_frame, "early header field marked last")

endmodule

bind nwk_header_parser nhp_checker u_nhp_checker (.*);
